/* design/ismt_pkg.sv */
// ----------------------------------------------------------------------------
// Integer set membership table package
// Shared sizes, operation codes and the request/result structs that pass
// between the top level and the match array.
// ----------------------------------------------------------------------------
`default_nettype none

package ismt_pkg;

  // Number of slots in the match array
  localparam int unsigned TABLE_DEPTH = 64;

  // Key width and width of the member count on the result channel
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 7;

  // Internal occupancy width: must hold TABLE_DEPTH itself
  localparam int unsigned OCC_W = $clog2(TABLE_DEPTH + 1);

  // Operation codes; the spare code behaves as a find
  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // Request presented to the match array in the cycle it is processed
  typedef struct packed {
    logic               fire;
    logic [1:0]         func;
    logic [KEY_W-1:0]   key_value;
  } cam_cmd_t;

  // Result returned by the match array for the request being processed
  typedef struct packed {
    logic               was_present;
    logic [COUNT_W-1:0] member_count;
    logic               insert_dropped;
  } cam_res_t;

endpackage

`default_nettype wire

/* design/ismt_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation code and one signed key.
// ----------------------------------------------------------------------------
`default_nettype none

interface ismt_req_if;

  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic signed [ismt_pkg::KEY_W-1:0] key_value;

  modport source (output valid, output func, output key_value, input ready);
  modport sink   (input valid, input func, input key_value, output ready);

endinterface

`default_nettype wire

/* design/ismt_rsp_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ismt_rsp_if;

  logic                             valid;
  logic                             ready;
  logic                             was_present;
  logic [ismt_pkg::COUNT_W-1:0]     member_count;
  logic                             insert_dropped;

  modport source (output valid, output was_present, output member_count,
                  output insert_dropped, input ready);
  modport sink   (input valid, input was_present, input member_count,
                  input insert_dropped, output ready);

endinterface

`default_nettype wire

/* design/integer_set_membership_table.sv */
// ----------------------------------------------------------------------------
// Integer set membership table
// Bounded set of distinct signed 32-bit keys held in a parallel match array.
//
// Usage:
//   req carries func (find, insert if absent, remove if present; the spare
//   code acts as find) and key_value. rsp returns one result per request:
//   was_present before the operation, member_count afterwards, and
//   insert_dropped when an insert of an absent key finds the table full.
//   Both channels move a request when valid and ready are high together.
//   The request is captured in an input register, then compared against
//   all slots while the table is updated and the result register loaded
//   at the same edge. Throughput is one request per cycle while the
//   receiver does not stall, using the parallel compare and lowest-free-slot
//   search of the match array; each update is in place before the next
//   request is compared. When the receiver stalls, the result register holds
//   and the input register takes one more request before req.ready drops.
//   Synchronous reset empties the set at once (all valid bits cleared, count
//   zero) and drops any request in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_set_membership_table (
  input  wire logic clk,
  input  wire logic rst,
  ismt_req_if.sink  req,
  ismt_rsp_if.source rsp
);

  // Input register
  logic                       req_valid_q;
  logic [1:0]                 req_func_q;
  logic [ismt_pkg::KEY_W-1:0] req_key_q;

  // Result register
  logic                         rsp_valid_q;
  logic                         rsp_present_q;
  logic [ismt_pkg::COUNT_W-1:0] rsp_count_q;
  logic                         rsp_dropped_q;

  logic               advance;
  logic               in_ready;
  ismt_pkg::cam_cmd_t cmd;
  ismt_pkg::cam_res_t res;

  // Stage moves when the result register is empty or being drained
  assign advance  = !rsp_valid_q || rsp.ready;
  assign in_ready = !req_valid_q || advance;
  assign req.ready = in_ready;

  // Capture incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid_q <= 1'b0;
    end else if (in_ready) begin
      req_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && req.valid) begin
      req_func_q <= req.func;
      req_key_q  <= req.key_value;
    end
  end

  // Match array
  assign cmd.fire      = req_valid_q && advance;
  assign cmd.func      = req_func_q;
  assign cmd.key_value = req_key_q;

  ismt_cam u_cam (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      rsp_present_q <= res.was_present;
      rsp_count_q   <= res.member_count;
      rsp_dropped_q <= res.insert_dropped;
    end
  end

  assign rsp.valid          = rsp_valid_q;
  assign rsp.was_present    = rsp_present_q;
  assign rsp.member_count   = rsp_count_q;
  assign rsp.insert_dropped = rsp_dropped_q;

endmodule

`default_nettype wire

/* design/ismt_cam.sv */
// ----------------------------------------------------------------------------
// Match array
// TABLE_DEPTH key slots with valid bits, compared in parallel against the
// incoming key. Inserts go to the lowest free slot; removes clear the
// matching slot. Slot contents and count update at the clock edge on which
// the request is processed, so the next request sees them.
// ----------------------------------------------------------------------------
`default_nettype none

module ismt_cam (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ismt_pkg::cam_cmd_t cmd,
  output ismt_pkg::cam_res_t     res
);

  localparam int unsigned DEPTH = ismt_pkg::TABLE_DEPTH;

  // Slot storage: keys have no reset, valid bits and count do
  logic [ismt_pkg::KEY_W-1:0] stored_values [DEPTH];
  logic [DEPTH-1:0]           entry_valid;
  logic [ismt_pkg::OCC_W-1:0] occupancy;

  logic [DEPTH-1:0]           entry_valid_next;
  logic [ismt_pkg::OCC_W-1:0] occupancy_next;

  logic [DEPTH-1:0] hit_vec;
  logic [DEPTH-1:0] free_onehot;
  logic             present;
  logic             full;
  logic             is_insert;
  logic             is_remove;
  logic             insert_ok;
  logic             remove_ok;

  // Parallel compare across all slots
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec[i] = entry_valid[i] && (stored_values[i] == cmd.key_value);
    end
  end

  assign present = |hit_vec;
  assign full    = &entry_valid;

  // Lowest free slot as a one-hot vector
  assign free_onehot = ~entry_valid & (entry_valid + DEPTH'(1));

  assign is_insert = (cmd.func == ismt_pkg::OP_INSERT);
  assign is_remove = (cmd.func == ismt_pkg::OP_REMOVE);
  assign insert_ok = cmd.fire && is_insert && !present && !full;
  assign remove_ok = cmd.fire && is_remove && present;

  // Next valid bits and count
  always_comb begin
    entry_valid_next = entry_valid;
    occupancy_next   = occupancy;
    if (insert_ok) begin
      entry_valid_next = entry_valid | free_onehot;
      occupancy_next   = occupancy + ismt_pkg::OCC_W'(1);
    end else if (remove_ok) begin
      entry_valid_next = entry_valid & ~hit_vec;
      occupancy_next   = occupancy - ismt_pkg::OCC_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
    end else begin
      entry_valid <= entry_valid_next;
      occupancy   <= occupancy_next;
    end
  end

  // Key write into the chosen free slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (insert_ok && free_onehot[i]) begin
        stored_values[i] <= cmd.key_value;
      end
    end
  end

  // Result for the request being processed
  assign res.was_present    = present;
  assign res.member_count   = occupancy_next[ismt_pkg::COUNT_W-1:0];
  assign res.insert_dropped = is_insert && !present && full;

endmodule

`default_nettype wire

/* bench/integer_set_membership_table_tb.sv */
// ----------------------------------------------------------------------------
// Integer set membership table testbench
// Sends find, insert and remove requests over the request channel, and keeps
// its own model of the set to predict each result. Every result is checked
// field by field against the oldest prediction. Both channels idle at random.
// The receiver also holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module integer_set_membership_table_tb;

  import ismt_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned KEY_POOL_N   = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 800_000;
  // Spare operation code, handled as a find
  localparam logic [1:0]  FUNC_SPARE   = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef struct {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key;
  } set_req_t;

  logic clk = 1'b0;
  logic rst;

  ismt_req_if req ();
  ismt_rsp_if rsp ();

  integer_set_membership_table u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Pending requests, and results predicted for accepted requests
  set_req_t    pending_reqs[$];
  cam_res_t    predicted_results[$];

  // Model of the set held by the block
  logic [KEY_W-1:0] set_keys [TABLE_DEPTH];
  logic             set_used [TABLE_DEPTH];
  int unsigned      set_size;

  int unsigned cycle_count = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned hold_mark = 300;

  logic signed [KEY_W-1:0] key_pool [KEY_POOL_N];

  always #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Applies one request to the model and returns the result it should give
  function automatic cam_res_t apply_request(set_req_t r);
    cam_res_t res;
    int hit;
    int free_idx;
    hit = -1;
    free_idx = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (set_used[i] && set_keys[i] == r.key && hit < 0) hit = i;
      if (!set_used[i] && free_idx < 0) free_idx = i;
    end
    res.was_present    = (hit >= 0);
    res.insert_dropped = 1'b0;
    if (r.func == OP_INSERT && hit < 0) begin
      if (free_idx >= 0) begin
        set_keys[free_idx] = r.key;
        set_used[free_idx] = 1'b1;
        set_size++;
      end else begin
        res.insert_dropped = 1'b1;
      end
    end else if (r.func == OP_REMOVE && hit >= 0) begin
      set_used[hit] = 1'b0;
      set_size--;
    end
    res.member_count = COUNT_W'(set_size);
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic queue_request(input logic [1:0] func, input logic signed [KEY_W-1:0] key);
    set_req_t r;
    r.func = func;
    r.key  = key;
    pending_reqs.push_back(r);
  endtask

  // Request driver; predicts the result of each request as it is accepted
  always @(posedge clk) begin : drive_blk
    set_req_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (req.valid && req.ready) begin
        nxt.func = req.func;
        nxt.key  = req.key_value;
        predicted_results.push_back(apply_request(nxt));
        accepted_count <= accepted_count + 1;
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          req.valid     <= 1'b1;
          req.func      <= nxt.func;
          req.key_value <= nxt.key;
          // calm stretches with back-to-back requests
          gap_left      <= (((cycle_count >> 9) % 4) == 0) ? 0 : pick_pause();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the result channel, twice during the run
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (accepted_count >= hold_mark) begin
      hold_left <= $urandom_range(150, 250);
      hold_mark <= hold_mark + 900;
    end
  end

  // Result ready: random stalls, with calm stretches
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready  <= 1'b0;
      stall_left <= 0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready  <= 1'b0;
    end else if (((cycle_count >> 9) % 4) != 2 && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_pause();
      rsp.ready  <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin : check_blk
    cam_res_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = predicted_results.pop_front();
        if (rsp.was_present !== want.was_present)
          report_mismatch($sformatf("was_present %b, expected %b",
                                    rsp.was_present, want.was_present));
        if (rsp.member_count !== want.member_count)
          report_mismatch($sformatf("member_count %0d, expected %0d",
                                    rsp.member_count, want.member_count));
        if (rsp.insert_dropped !== want.insert_dropped)
          report_mismatch($sformatf("insert_dropped %b, expected %b",
                                    rsp.insert_dropped, want.insert_dropped));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Stimulus and end of run
  initial begin : main_blk
    int unsigned made;
    int unsigned phase_len;
    int unsigned w_ins;
    int unsigned w_rem;
    int unsigned roll;
    int unsigned queued_total;
    logic [1:0] func;
    logic signed [KEY_W-1:0] key;

    rst           = 1'b1;
    req.valid     = 1'b0;
    req.func      = OP_FIND;
    req.key_value = '0;
    rsp.ready     = 1'b0;
    set_size      = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      set_used[i] = 1'b0;
      set_keys[i] = '0;
    end

    // Directed: extremes, every operation, spare code, absent and present cases
    queue_request(OP_FIND, 0);
    queue_request(OP_REMOVE, 0);
    queue_request(OP_INSERT, KEY_MIN);
    queue_request(OP_INSERT, KEY_MAX);
    queue_request(OP_INSERT, 0);
    queue_request(OP_INSERT, -1);
    queue_request(OP_INSERT, KEY_MIN);
    queue_request(OP_FIND, KEY_MAX);
    queue_request(FUNC_SPARE, -1);
    queue_request(FUNC_SPARE, 1);
    queue_request(OP_REMOVE, KEY_MAX);
    queue_request(OP_FIND, KEY_MAX);
    queue_request(OP_INSERT, 32'sh5555_5555);
    queue_request(OP_INSERT, 32'shAAAA_AAAA);
    queue_request(OP_REMOVE, KEY_MIN);
    queue_request(OP_INSERT, 1);
    queue_request(OP_REMOVE, -1);
    queue_request(OP_REMOVE, 0);
    queue_request(OP_REMOVE, 1);
    queue_request(OP_REMOVE, 32'sh5555_5555);
    queue_request(OP_REMOVE, 32'shAAAA_AAAA);
    queue_request(OP_REMOVE, 32'shAAAA_AAAA);

    // Key pool larger than the table, so fill phases reach a full table
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < KEY_POOL_N; i++) key_pool[i] = $urandom;

    // Random phases: filling, draining, balanced and lookup-heavy mixes
    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase_len = $urandom_range(100, 200);
      case ($urandom_range(0, 3))
        0: begin w_ins = 60; w_rem = 10; end
        1: begin w_ins = 10; w_rem = 60; end
        2: begin w_ins = 35; w_rem = 35; end
        default: begin w_ins = 20; w_rem = 20; end
      endcase
      for (int n = 0; n < phase_len && made < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < w_ins) func = OP_INSERT;
        else if (roll < w_ins + w_rem) func = OP_REMOVE;
        else if (roll < 95) func = OP_FIND;
        else func = FUNC_SPARE;
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        else key = $urandom;
        queue_request(func, key);
        made++;
      end
    end
    queued_total = pending_reqs.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be accepted and every result to come back
    while (accepted_count < queued_total || predicted_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ismt_pkg.sv
design/ismt_req_if.sv
design/ismt_rsp_if.sv
design/ismt_cam.sv
design/integer_set_membership_table.sv
bench/integer_set_membership_table_tb.sv
